// ===== rtl/core/sdaf_pkg.sv =====
// ----------------------------------------------------------------------------
// sdaf_pkg
// Shared widths, character codes and the cell control type of the signed
// decimal ASCII formatter.
// ----------------------------------------------------------------------------
package sdaf_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int DIGIT_W     = 4;
    localparam int NUM_DIGITS  = (VALUE_WIDTH * 3) / 10 + 1;
    localparam int CHAR_W      = 6;
    localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH);
    localparam int REM_W       = $clog2(NUM_DIGITS + 1);

    localparam logic [CHAR_W-1:0]  CHAR_MINUS   = CHAR_W'(45);
    localparam logic [CHAR_W-1:0]  CHAR_ZERO    = CHAR_W'(48);
    localparam logic [DIGIT_W-1:0] ADJ_LIMIT    = DIGIT_W'(5);
    localparam logic [DIGIT_W-1:0] ADJ_ADDEND   = DIGIT_W'(3);

    typedef struct packed {
        logic clear;
        logic convert;
        logic shift;
    } sdaf_cell_ctrl_t;

endpackage

// ===== rtl/core/sdaf_if.sv =====
// ----------------------------------------------------------------------------
// sdaf_if
// Valid/ready channels of the formatter: the signed value in and the
// characters out.
// ----------------------------------------------------------------------------
interface sdaf_value_if import sdaf_pkg::*; ();

    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);

endinterface

interface sdaf_char_if import sdaf_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic              last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);

endinterface

// ===== rtl/core/sdaf_cell.sv =====
// ----------------------------------------------------------------------------
// sdaf_cell
// One decimal digit of the conversion chain. It adds three when the digit is
// five or more and shifts in one bit from its lower neighbor, or moves the
// lower neighbor's digit up during readout.
// ----------------------------------------------------------------------------
module sdaf_cell import sdaf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  sdaf_cell_ctrl_t      ctrl,
    input  logic                 bit_in,
    input  logic [DIGIT_W-1:0]   digit_in,
    output logic                 bit_out,
    output logic [DIGIT_W-1:0]   digit
);

    logic [DIGIT_W-1:0] digit_reg;
    logic [DIGIT_W-1:0] digit_next;
    logic [DIGIT_W-1:0] adj;

    assign adj     = (digit_reg >= ADJ_LIMIT) ? digit_reg + ADJ_ADDEND : digit_reg;
    assign bit_out = adj[DIGIT_W-1];
    assign digit   = digit_reg;

    always_comb
    begin
        digit_next = digit_reg;
        if (ctrl.clear)
        begin
            digit_next = '0;
        end
        else if (ctrl.convert)
        begin
            digit_next = {adj[DIGIT_W-2:0], bit_in};
        end
        else if (ctrl.shift)
        begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= '0;
        end
        else
        begin
            digit_reg <= digit_next;
        end
    end

endmodule

// ===== rtl/core/signed_decimal_ascii_formatter_unit.sv =====
// ----------------------------------------------------------------------------
// signed_decimal_ascii_formatter_unit
// Formats a signed value as decimal ASCII text, one character per item,
// most significant digit first, with a leading minus sign when negative.
// ----------------------------------------------------------------------------
//  Channel   Role     Payload
//  operand   sink     value (signed, VALUE_WIDTH bits)
//  text      source   character (6 bits), last
//
//  An accepted value is shifted into a chain of decimal digit cells, one bit
//  per cycle. Leading zero digits are then dropped at one per cycle, and each
//  digit character leaves at one per cycle while the text channel is ready.
//  A new value is accepted only once the last character of the previous one
//  has been issued, so text stalls also delay the next acceptance.
//  Reset clears the controller, the digit cells and the output valid flag;
//  a stalled text channel holds the current character and pauses the readout.
// ----------------------------------------------------------------------------
module signed_decimal_ascii_formatter_unit import sdaf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    sdaf_value_if.sink        operand,
    sdaf_char_if.source       text
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CONV = 3'd1;
    localparam logic [2:0] ST_SIGN = 3'd2;
    localparam logic [2:0] ST_SKIP = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0]             state_reg, state_next;
    logic [VALUE_WIDTH-1:0] mag_reg, mag_next;
    logic                   neg_reg, neg_next;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [REM_W-1:0]       remain_reg, remain_next;
    logic                   out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]      char_reg, char_next;
    logic                   last_reg, last_next;

    sdaf_cell_ctrl_t        cell_ctrl;
    logic                   bit_chain [NUM_DIGITS+1];
    logic [DIGIT_W-1:0]     digit_chain [NUM_DIGITS+1];
    logic [DIGIT_W-1:0]     top_digit;
    logic                   out_free;

    assign bit_chain[0]   = mag_reg[VALUE_WIDTH-1];
    assign digit_chain[0] = '0;
    assign top_digit      = digit_chain[NUM_DIGITS];
    assign out_free       = !out_valid_reg || text.ready;

    generate
        for (genvar i = 0; i < NUM_DIGITS; i++)
        begin : g_cell
            sdaf_cell u_cell
            (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (cell_ctrl),
                .bit_in   (bit_chain[i]),
                .digit_in (digit_chain[i]),
                .bit_out  (bit_chain[i+1]),
                .digit    (digit_chain[i+1])
            );
        end
    endgenerate

    assign operand.ready  = (state_reg == ST_IDLE);
    assign text.valid     = out_valid_reg;
    assign text.character = char_reg;
    assign text.last      = last_reg;

    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        bit_cnt_next   = bit_cnt_reg;
        remain_next    = remain_reg;
        out_valid_next = out_valid_reg && !text.ready;
        char_next      = char_reg;
        last_next      = last_reg;
        cell_ctrl      = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (operand.valid)
                begin
                    neg_next        = operand.value[VALUE_WIDTH-1];
                    mag_next        = operand.value[VALUE_WIDTH-1]
                                      ? VALUE_WIDTH'(-operand.value) : operand.value;
                    bit_cnt_next    = BIT_CNT_W'(VALUE_WIDTH - 1);
                    remain_next     = REM_W'(NUM_DIGITS);
                    cell_ctrl.clear = 1'b1;
                    state_next      = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cell_ctrl.convert = 1'b1;
                mag_next          = mag_reg << 1;
                bit_cnt_next      = bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == '0)
                begin
                    state_next = ST_SIGN;
                end
            end
            ST_SIGN:
            begin
                if (!neg_reg)
                begin
                    state_next = ST_SKIP;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = CHAR_MINUS;
                    last_next      = 1'b0;
                    state_next     = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if ((top_digit == '0) && (remain_reg > REM_W'(1)))
                begin
                    cell_ctrl.shift = 1'b1;
                    remain_next     = remain_reg - 1'b1;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    char_next       = CHAR_ZERO + CHAR_W'(top_digit);
                    last_next       = (remain_reg == REM_W'(1));
                    cell_ctrl.shift = 1'b1;
                    remain_next     = remain_reg - 1'b1;
                    if (remain_reg == REM_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            bit_cnt_reg   <= '0;
            remain_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            bit_cnt_reg   <= bit_cnt_next;
            remain_reg    <= remain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

endmodule

// ===== dv/sdaf_text_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sdaf_text_checker
// Watches both channels of the formatter. Each accepted value is turned into
// its expected decimal text, and every character that leaves is compared,
// character code and last flag, with the oldest expected character.
// ----------------------------------------------------------------------------
module sdaf_text_checker import sdaf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    sdaf_value_if operand,
    sdaf_char_if  text,
    output int    fail_count,
    output int    pending
);

    localparam int DECIMAL_RADIX = 10;
    localparam int MAX_TEXT_DIGITS = 20;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
    } text_char_t;

    text_char_t expected_chars[$];
    int         mismatch_total = 0;

    function automatic void predict_text(input logic signed [VALUE_WIDTH-1:0] value);
        logic [VALUE_WIDTH-1:0] magnitude;
        logic [DIGIT_W-1:0]     digits [MAX_TEXT_DIGITS];
        int                     count;
        text_char_t             entry;
        magnitude = $unsigned(value);
        if (value[VALUE_WIDTH-1])
        begin
            magnitude = ~magnitude + 1'b1;
        end
        count = 0;
        do
        begin
            digits[count] = DIGIT_W'(magnitude % DECIMAL_RADIX);
            magnitude     = magnitude / DECIMAL_RADIX;
            count++;
        end
        while (magnitude != 0);
        if (value[VALUE_WIDTH-1])
        begin
            entry.character = CHAR_MINUS;
            entry.last      = 1'b0;
            expected_chars.push_back(entry);
        end
        for (int i = count - 1; i >= 0; i--)
        begin
            entry.character = CHAR_ZERO + CHAR_W'(digits[i]);
            entry.last      = (i == 0);
            expected_chars.push_back(entry);
        end
    endfunction

    always @(posedge clk)
    begin
        text_char_t want;
        if (rst_n)
        begin
            if (operand.valid && operand.ready)
            begin
                predict_text(operand.value);
            end
            if (text.valid && text.ready)
            begin
                if (expected_chars.size() == 0)
                begin
                    $display("%0t: unexpected character: expected none, actual %0d last %0b",
                             $time, text.character, text.last);
                    mismatch_total++;
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (text.character !== want.character)
                    begin
                        $display("%0t: character mismatch: expected %0d, actual %0d",
                                 $time, want.character, text.character);
                        mismatch_total++;
                    end
                    if (text.last !== want.last)
                    begin
                        $display("%0t: last flag mismatch: expected %0b, actual %0b",
                                 $time, want.last, text.last);
                        mismatch_total++;
                    end
                end
            end
        end
        fail_count <= mismatch_total;
        pending    <= expected_chars.size();
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives signed values into the formatter, directed corner values first and
// then random values of every length and sign, while the text side stalls at
// random and once for a long stretch. A separate checker predicts the text.
// ----------------------------------------------------------------------------
module testbench;
    import sdaf_pkg::*;

    localparam int RANDOM_ITEMS   = 470;
    localparam int QUIET_START    = 300;
    localparam int QUIET_END      = 380;
    localparam int HOLD_AT_ITEM   = 120;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 64;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int NUM_EDGE       = 22;

    localparam logic signed [VALUE_WIDTH-1:0] EDGE_VALUES [NUM_EDGE] = '{
        32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10,
        32'sd99, 32'sd100, -32'sd100, 32'sh7FFF_FFFF, 32'sh8000_0000,
        32'sh8000_0001, 32'sh7FFF_FFFE, 32'sd1000000000, 32'sd999999999,
        -32'sd1000000000, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sd1234567890,
        -32'sd1234567890, 32'sd5
    };

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   items_sent = 0;
    int   idle_cycles = 0;

    sdaf_value_if operand ();
    sdaf_char_if  text ();

    signed_decimal_ascii_formatter_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .operand (operand),
        .text    (text)
    );

    sdaf_text_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .operand    (operand),
        .text       (text),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #6;
        clk = 1'b1;
        #6;
        clk = 1'b0;
    end

    function automatic logic signed [VALUE_WIDTH-1:0] random_value();
        longint limit;
        longint magnitude;
        int     kind;
        kind = $urandom_range(0, 3);
        case (kind)
            0: magnitude = longint'($signed($urandom()));
            1:
            begin
                limit = 10 ** $urandom_range(1, 10) - 1;
                if (limit > 64'sd2147483647)
                begin
                    limit = 64'sd2147483647;
                end
                magnitude = $urandom_range(0, 32'(limit));
            end
            2: magnitude = 10 ** $urandom_range(0, 9) + $urandom_range(0, 2) - 1;
            default: magnitude = 64'sd2147483647 - $urandom_range(0, 20);
        endcase
        if (kind != 0 && $urandom_range(0, 1) == 1)
        begin
            magnitude = -magnitude - ((kind == 3) ? 1 : 0);
        end
        return VALUE_WIDTH'(magnitude);
    endfunction

    function automatic bit in_quiet_stretch();
        return items_sent >= QUIET_START && items_sent < QUIET_END;
    endfunction

    task automatic send_value(input logic signed [VALUE_WIDTH-1:0] v);
        while (!in_quiet_stretch() && $urandom_range(0, 99) < 25)
        begin
            operand.valid <= 1'b0;
            @(posedge clk);
        end
        operand.valid <= 1'b1;
        operand.value <= v;
        do
        begin
            @(posedge clk);
        end
        while (!operand.ready);
        items_sent++;
    endtask

    initial
    begin
        rst_n <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        text.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                text.ready <= 1'b0;
            end
            else if (!hold_done && items_sent >= HOLD_AT_ITEM)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                text.ready <= 1'b0;
            end
            else if (in_quiet_stretch())
            begin
                text.ready <= 1'b1;
            end
            else
            begin
                text.ready <= ($urandom_range(0, 99) >= 25);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((operand.valid && operand.ready) || (text.valid && text.ready))
            begin
                idle_cycles <= 0;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        operand.valid <= 1'b0;
        operand.value <= '0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        for (int i = 0; i < NUM_EDGE; i++)
        begin
            send_value(EDGE_VALUES[i]);
        end
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            send_value(random_value());
        end
        operand.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
